// ===== rtl/bidx_pkg.sv =====
// shared types and constants of the box index translator
package bidx_pkg;

    localparam int IDX_W           = 64;
    localparam int REG_W           = 64;
    localparam int SLOT_W          = 16;
    localparam int DIMS_W          = 3;
    localparam int STEP_BITS       = 4;
    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_COORD_WIDTH = 16;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DIM_COUNT = 2'd0,
        REG_BOX_BEGIN = 2'd1,
        REG_BOX_SIZE  = 2'd2,
        REG_GRID_EXT  = 2'd3
    } t_reg;

    // translation direction
    typedef enum logic {
        CMD_L2G = 1'b0,
        CMD_G2L = 1'b1
    } t_cmd;

    // configuration as seen by every cell
    typedef struct packed {
        logic [DIMS_W-1:0] dims;
        logic [REG_W-1:0]  box_begin;
        logic [REG_W-1:0]  box_size;
        logic [REG_W-1:0]  grid_ext;
    } t_cfg;

    // word handed from cell to cell
    typedef struct packed {
        t_cmd             cmd;
        logic             ok;
        logic [IDX_W-1:0] rest;
        logic [IDX_W-1:0] acc;
        logic [IDX_W-1:0] stride;
    } t_word;

endpackage

// ===== rtl/box_index_translator.sv =====
// top level of the box index translator
// Translates one linear index per clock cycle, while the output does not stall,
// between a box's local row-major index and the enclosing grid's global
// row-major index (dimension 0 fastest). Each dimension is one cell of a chain;
// a cell holds a radix-16 divider of 64/4 = 16 stages followed by 4 stages of
// range check and split stride multiply, and a new index can enter every cycle
// unless the output stalls. Stalls on the output back up stage by stage, so
// empty stages keep accepting input. Indexes outside the box return index 0
// with found low. Configuration is written through a plain write port and must
// only change while no word is in flight.
module box_index_translator #(
    parameter int MAX_DIMS    = bidx_pkg::DEF_MAX_DIMS,
    parameter int COORD_WIDTH = bidx_pkg::DEF_COORD_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [bidx_pkg::REG_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_command,
    input  logic [bidx_pkg::IDX_W-1:0] i_index_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bidx_pkg::IDX_W-1:0] o_index_out,
    output logic                       o_found
);
    import bidx_pkg::*;

    logic [DIMS_W-1:0] r_dim_count;
    logic [REG_W-1:0]  r_box_begin;
    logic [REG_W-1:0]  r_box_size;
    logic [REG_W-1:0]  r_grid_ext;
    logic [DIMS_W-1:0] dims;
    t_cfg              cfg;

    t_word chain_w   [MAX_DIMS+1];
    logic  chain_v   [MAX_DIMS+1];
    logic  chain_rdy [MAX_DIMS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DIMS_W'(1);
            r_box_begin <= '0;
            r_box_size  <= '0;
            r_grid_ext  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_DIM_COUNT: r_dim_count <= i_cfg_data[DIMS_W-1:0];
                REG_BOX_BEGIN: r_box_begin <= i_cfg_data;
                REG_BOX_SIZE:  r_box_size  <= i_cfg_data;
                REG_GRID_EXT:  r_grid_ext  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions in use, clamped to the supported range
    always_comb begin
        dims = r_dim_count;
        if (r_dim_count == '0) begin
            dims = DIMS_W'(1);
        end else if (r_dim_count > DIMS_W'(MAX_DIMS)) begin
            dims = DIMS_W'(MAX_DIMS);
        end
    end

    assign cfg = '{dims: dims, box_begin: r_box_begin, box_size: r_box_size,
                   grid_ext: r_grid_ext};

    // chain input word
    assign chain_v[0] = i_valid;
    assign o_ready    = chain_rdy[0];
    assign chain_w[0] = '{cmd: t_cmd'(i_command), ok: 1'b1, rest: i_index_in,
                          acc: '0, stride: IDX_W'(1)};

    // one cell per dimension
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
        bidx_cell #(
            .DIM         (d),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg),
            .i_valid (chain_v[d]),
            .o_ready (chain_rdy[d]),
            .i_word  (chain_w[d]),
            .o_valid (chain_v[d+1]),
            .i_ready (chain_rdy[d+1]),
            .o_word  (chain_w[d+1])
        );
    end

    // result from the last cell's output register
    assign chain_rdy[MAX_DIMS] = i_ready;
    assign o_valid             = chain_v[MAX_DIMS];
    assign o_found             = chain_w[MAX_DIMS].ok;
    assign o_index_out         = chain_w[MAX_DIMS].ok ? chain_w[MAX_DIMS].acc : '0;

endmodule

// ===== rtl/bidx_cell.sv =====
// one dimension of the chain: pipelined digit divider, range check and stride multiply
module bidx_cell #(
    parameter int DIM         = 0,
    parameter int COORD_WIDTH = bidx_pkg::DEF_COORD_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bidx_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  bidx_pkg::t_word i_word,
    output logic            o_valid,
    input  logic            i_ready,
    output bidx_pkg::t_word o_word
);
    import bidx_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int NDIV = IDX_W / STEP_BITS;
    localparam int NST  = NDIV + 4;
    localparam int HALF = IDX_W / 2;
    localparam int PW   = DW + HALF;
    localparam int SA   = NDIV;
    localparam int SB   = NDIV + 1;
    localparam int SC   = NDIV + 2;
    localparam int SD   = NDIV + 3;

    logic [CW-1:0] f_begin;
    logic [CW-1:0] f_size;
    logic [CW-1:0] f_ext;
    logic [DW-1:0] d_l2g;
    logic [DW-1:0] d_g2l;
    logic          active;
    logic          last;

    logic          r_v [NST];
    logic          en  [NST];

    t_word            r_dw   [NDIV];
    logic [CW-1:0]    r_rem  [NDIV];
    logic [IDX_W-1:0] r_orig [NDIV];

    t_word         n_a_w;
    logic [DW-1:0] n_a_val;
    logic [DW-1:0] n_a_mm;
    t_word         r_a_w;
    logic [DW-1:0] r_a_val;
    logic [DW-1:0] r_a_mm;
    t_word         r_b_w;
    logic [DW-1:0] r_b_val;
    logic [DW-1:0] r_b_mm;
    logic [PW-1:0] r_b_tl;
    logic [PW-1:0] r_b_sl;
    t_word         r_c_w;
    logic [PW-1:0] r_c_tl;
    logic [PW-1:0] r_c_sl;
    logic [PW-1:0] r_c_th;
    logic [PW-1:0] r_c_sh;
    t_word         n_d_w;
    t_word         r_d_w;

    // this dimension's coordinates and divisors
    assign f_begin = i_cfg.box_begin[SLOT_W*DIM +: CW];
    assign f_size  = i_cfg.box_size[SLOT_W*DIM +: CW];
    assign f_ext   = i_cfg.grid_ext[SLOT_W*DIM +: CW];
    assign d_l2g   = {1'b0, f_size} + DW'(1);
    assign d_g2l   = {1'b0, f_ext} + DW'(1);
    assign active  = DIMS_W'(DIM) < i_cfg.dims;
    assign last    = i_cfg.dims == DIMS_W'(DIM + 1);

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // divider stages, STEP_BITS quotient bits each
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        t_word            src_w;
        logic [CW-1:0]    src_rem;
        logic [IDX_W-1:0] src_orig;
        t_word            n_w;
        logic [CW-1:0]    n_rem;
        logic [DW-1:0]    dv;
        logic [DW-1:0]    trial;

        if (k == 0) begin : g_first
            assign src_w    = i_word;
            assign src_rem  = '0;
            assign src_orig = i_word.rest;
        end else begin : g_next
            assign src_w    = r_dw[k-1];
            assign src_rem  = r_rem[k-1];
            assign src_orig = r_orig[k-1];
        end

        // restoring steps, quotient bits shift in behind the dividend
        always_comb begin
            n_w   = src_w;
            n_rem = src_rem;
            dv    = (src_w.cmd == CMD_G2L) ? d_g2l : d_l2g;
            trial = '0;
            for (int j = 0; j < STEP_BITS; j++) begin
                trial    = {n_rem, n_w.rest[IDX_W-1]};
                n_w.rest = {n_w.rest[IDX_W-2:0], 1'b0};
                if (trial >= dv) begin
                    trial       = trial - dv;
                    n_w.rest[0] = 1'b1;
                end
                n_rem = trial[CW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_dw[k]   <= n_w;
                r_rem[k]  <= n_rem;
                r_orig[k] <= src_orig;
            end
        end
    end

    // coordinate, range check and stride factor
    always_comb begin
        n_a_w   = r_dw[NDIV-1];
        n_a_val = '0;
        n_a_mm  = DW'(1);
        if (!active) begin
            n_a_w.rest = r_orig[NDIV-1];
        end else if (r_dw[NDIV-1].cmd == CMD_L2G) begin
            if (last && (r_dw[NDIV-1].rest != '0)) begin
                n_a_w.ok = 1'b0;
            end
            n_a_val = {1'b0, f_begin} + {1'b0, r_rem[NDIV-1]};
            n_a_mm  = d_g2l;
        end else begin
            if (last) begin
                if ((r_orig[NDIV-1] < IDX_W'(f_begin)) ||
                    ((r_orig[NDIV-1] - IDX_W'(f_begin)) > IDX_W'(f_size))) begin
                    n_a_w.ok = 1'b0;
                end
                n_a_val = DW'(r_orig[NDIV-1] - IDX_W'(f_begin));
            end else begin
                if ((r_rem[NDIV-1] < f_begin) ||
                    (({1'b0, r_rem[NDIV-1]} - {1'b0, f_begin}) > {1'b0, f_size})) begin
                    n_a_w.ok = 1'b0;
                end
                n_a_val = {1'b0, r_rem[NDIV-1]} - {1'b0, f_begin};
            end
            n_a_mm = d_l2g;
        end
    end

    // final sum of the partial products
    always_comb begin
        n_d_w        = r_c_w;
        n_d_w.acc    = r_c_w.acc + IDX_W'(r_c_tl) + {r_c_th[HALF-1:0], {HALF{1'b0}}};
        n_d_w.stride = IDX_W'(r_c_sl) + {r_c_sh[HALF-1:0], {HALF{1'b0}}};
    end

    // multiply stages, the 64-bit stride taken in two halves
    always_ff @(posedge i_clk) begin
        if (en[SA]) begin
            r_a_w   <= n_a_w;
            r_a_val <= n_a_val;
            r_a_mm  <= n_a_mm;
        end
        if (en[SB]) begin
            r_b_w   <= r_a_w;
            r_b_val <= r_a_val;
            r_b_mm  <= r_a_mm;
            r_b_tl  <= PW'(r_a_val) * PW'(r_a_w.stride[HALF-1:0]);
            r_b_sl  <= PW'(r_a_mm) * PW'(r_a_w.stride[HALF-1:0]);
        end
        if (en[SC]) begin
            r_c_w  <= r_b_w;
            r_c_tl <= r_b_tl;
            r_c_sl <= r_b_sl;
            r_c_th <= PW'(r_b_val) * PW'(r_b_w.stride[IDX_W-1:HALF]);
            r_c_sh <= PW'(r_b_mm) * PW'(r_b_w.stride[IDX_W-1:HALF]);
        end
        if (en[SD]) begin
            r_d_w <= n_d_w;
        end
    end

    assign o_valid = r_v[SD];
    assign o_word  = r_d_w;

endmodule

// ===== rtl/bidx_chk.sv =====
// port checks for the box index translator, bound to the top level
module bidx_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       i_command,
    input logic [bidx_pkg::IDX_W-1:0] i_index_in,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [bidx_pkg::IDX_W-1:0] o_index_out,
    input logic                       o_found
);
    import bidx_pkg::*;

    // a word that is not found carries index zero
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_index_out == '0))
        else $error("word not found but index nonzero");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_index_out) && $stable(o_found)))
        else $error("stalled result changed");

    // an offered input word holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_command) && $stable(i_index_in)))
        else $error("offered input word changed");

endmodule

bind box_index_translator bidx_chk u_bidx_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_command   (i_command),
    .i_index_in  (i_index_in),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_index_out (o_index_out),
    .o_found     (o_found)
);
